// ===== hdl/hfcb_pkg.sv =====
// Package with the shared types and fixed field widths of the Huffman code builder.
package hfcb_pkg;

  // Fixed widths of the result fields.
  localparam int CODE_W = 63;
  localparam int LEN_W  = 6;
  localparam int IDX_W  = 6;
  localparam int IN_W   = 16;

  // Sequencer states of the builder.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MERGE1,
    S_MERGE2,
    S_MERGE3,
    S_WALK_RD,
    S_WALK_EV,
    S_EMIT
  } state_t;

endpackage

// ===== hdl/hfcb_node_mem.sv =====
// Node record memory: one write port and one registered read port.
module hfcb_node_mem #(
  parameter int DEPTH = 127,
  parameter int AW    = 7,
  parameter int DW    = 30
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/hfcb_builder.sv =====
// Sequencer that loads leaves, merges nodes in memory and walks each leaf to the root.
module hfcb_builder import hfcb_pkg::*; #(
  parameter int MAX_LEAVES  = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IN_W-1:0]   leaf_weight,
  input  logic              last_leaf,
  output logic              emit_valid,
  input  logic              emit_ready,
  output logic [IDX_W-1:0]  emit_index,
  output logic [CODE_W-1:0] emit_code,
  output logic [LEN_W-1:0]  emit_length,
  output logic              emit_last
);

  localparam int NODES = 2 * MAX_LEAVES - 1;
  localparam int NB    = $clog2(NODES);
  localparam int CW    = $clog2(MAX_LEAVES + 1);
  localparam int SUM_W = WEIGHT_BITS + $clog2(MAX_LEAVES);
  localparam int MW    = SUM_W + NB + 1;
  localparam int WIN   = (WEIGHT_BITS < IN_W) ? WEIGHT_BITS : IN_W;

  state_t state, state_next;

  logic [CW-1:0]     loaded, loaded_next, n_leaves, leaf;
  logic [NB-1:0]     node_i, end_i, scan_j, rd_idx, cur;
  logic              pend;
  logic              have1, have2;
  logic [NB-1:0]     p1, p2;
  logic [SUM_W-1:0]  w1, w2;
  logic [NODES-1:0]  parent_valid;
  logic [CODE_W-1:0] code;
  logic [LEN_W-1:0]  len;

  logic              mem_we;
  logic [NB-1:0]     mem_waddr, mem_raddr;
  logic [MW-1:0]     mem_wdata, mem_rdata;
  logic [SUM_W-1:0]  rd_weight;
  logic [NB-1:0]     rd_parent;
  logic              rd_is_left;
  logic              in_fire, last_done;

  hfcb_node_mem #(.DEPTH(NODES), .AW(NB), .DW(MW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_weight  = mem_rdata[MW-1 -: SUM_W];
  assign rd_parent  = mem_rdata[NB:1];
  assign rd_is_left = mem_rdata[0];

  assign in_fire     = in_valid && in_ready;
  assign loaded_next = (loaded < CW'(MAX_LEAVES)) ? loaded + 1'b1 : loaded;
  assign last_done   = (leaf == n_leaves - 1'b1);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && last_leaf) begin
          state_next = (loaded_next >= CW'(2)) ? S_SCAN : S_WALK_RD;
        end
      end
      S_SCAN: begin
        if (scan_j == node_i && !pend) state_next = S_MERGE1;
      end
      S_MERGE1: state_next = S_MERGE2;
      S_MERGE2: state_next = S_MERGE3;
      S_MERGE3: state_next = (node_i + 1'b1 == end_i) ? S_WALK_RD : S_SCAN;
      S_WALK_RD: state_next = S_WALK_EV;
      S_WALK_EV: state_next = parent_valid[cur] ? S_WALK_RD : S_EMIT;
      S_EMIT: begin
        if (emit_ready) state_next = last_done ? S_IDLE : S_WALK_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory control and handshake outputs.
  always_comb begin
    in_ready   = 1'b0;
    emit_valid = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = node_i;
    mem_wdata  = '0;
    mem_raddr  = scan_j;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        mem_we    = in_valid && (loaded < CW'(MAX_LEAVES));
        mem_waddr = NB'(loaded);
        mem_wdata = {SUM_W'(leaf_weight[WIN-1:0]), NB'(0), 1'b0};
      end
      S_MERGE1: begin
        mem_we    = 1'b1;
        mem_waddr = p1;
        mem_wdata = {w1, node_i, 1'b1};
      end
      S_MERGE2: begin
        mem_we    = 1'b1;
        mem_waddr = p2;
        mem_wdata = {w2, node_i, 1'b0};
      end
      S_MERGE3: begin
        mem_we    = 1'b1;
        mem_waddr = node_i;
        mem_wdata = {w1 + w2, NB'(0), 1'b0};
      end
      S_WALK_RD: mem_raddr = cur;
      S_EMIT:    emit_valid = 1'b1;
      default: ;
    endcase
  end

  assign emit_index  = IDX_W'(leaf);
  assign emit_code   = code;
  assign emit_length = len;
  assign emit_last   = last_done;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control counters and parent valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded       <= '0;
      parent_valid <= '0;
      pend         <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) loaded <= last_leaf ? '0 : loaded_next;
        end
        S_SCAN:   pend <= (scan_j < node_i);
        S_MERGE1: parent_valid[p1] <= 1'b1;
        S_MERGE2: parent_valid[p2] <= 1'b1;
        S_EMIT: begin
          if (emit_ready && last_done) parent_valid <= '0;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers for the scan, merge and walk.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        n_leaves <= loaded_next;
        end_i    <= NB'(2 * loaded_next - 1);
        node_i   <= NB'(loaded_next);
        scan_j   <= '0;
        have1    <= 1'b0;
        have2    <= 1'b0;
        leaf     <= '0;
        cur      <= '0;
        code     <= '0;
        len      <= '0;
      end
      S_SCAN: begin
        rd_idx <= scan_j;
        if (scan_j < node_i) scan_j <= scan_j + 1'b1;
        // Keep the two smallest parentless nodes; lower index wins ties.
        if (pend && !parent_valid[rd_idx]) begin
          if (!have1 || rd_weight < w1) begin
            if (have1) begin
              p2    <= p1;
              w2    <= w1;
              have2 <= 1'b1;
            end
            p1    <= rd_idx;
            w1    <= rd_weight;
            have1 <= 1'b1;
          end else if (!have2 || rd_weight < w2) begin
            p2    <= rd_idx;
            w2    <= rd_weight;
            have2 <= 1'b1;
          end
        end
      end
      S_MERGE3: begin
        node_i <= node_i + 1'b1;
        scan_j <= '0;
        have1  <= 1'b0;
        have2  <= 1'b0;
      end
      S_WALK_EV: begin
        // One level up: record this node's side and move to its parent.
        if (parent_valid[cur]) begin
          code <= code | (CODE_W'(!rd_is_left) << len);
          len  <= len + 1'b1;
          cur  <= rd_parent;
        end
      end
      S_EMIT: begin
        if (emit_ready) begin
          leaf <= leaf + 1'b1;
          cur  <= NB'(leaf + 1'b1);
          code <= '0;
          len  <= '0;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_j <= node_i))
    else $error("scan address ran past the node being built");

  a_two_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE1) |-> (have1 && have2 && p1 != p2))
    else $error("merge started without two distinct parentless nodes");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (parent_valid == '0))
    else $error("parent links left over while idle");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && emit_ready && last_done) |=> (loaded == '0))
    else $error("leaf count not cleared after the final code");
`endif

endmodule

// ===== hdl/huffman_tree_code_builder_top.sv =====
// Huffman code builder: loads leaf weights, builds the tree and delivers one code per leaf.
// Throughput: one leaf transaction per cycle while loading; in_ready stays low from the final
// leaf until the last code has left the builder. The build does n-1 merges; each scans the
// nodes below the new one with one node memory read per cycle, then writes the two parent links
// and the new node. Each leaf is then walked up to the root, and its code is registered at the outputs.
// Reset (rst, synchronous) empties the leaf set and clears all parent links.
module huffman_tree_code_builder_top import hfcb_pkg::*; #(
  parameter int MAX_LEAVES  = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IN_W-1:0]   leaf_weight,
  input  logic              last_leaf,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  leaf_index,
  output logic [CODE_W-1:0] code_bits,
  output logic [LEN_W-1:0]  code_length,
  output logic              last_code
);

  logic              emit_valid, emit_ready;
  logic [IDX_W-1:0]  emit_index;
  logic [CODE_W-1:0] emit_code;
  logic [LEN_W-1:0]  emit_length;
  logic              emit_last;

  hfcb_builder #(.MAX_LEAVES(MAX_LEAVES), .WEIGHT_BITS(WEIGHT_BITS)) u_builder (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .leaf_weight (leaf_weight),
    .last_leaf   (last_leaf),
    .emit_valid  (emit_valid),
    .emit_ready  (emit_ready),
    .emit_index  (emit_index),
    .emit_code   (emit_code),
    .emit_length (emit_length),
    .emit_last   (emit_last)
  );

  // Output register holds one transaction until it is taken.
  assign emit_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_ready) begin
      out_valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready && emit_valid) begin
      leaf_index  <= emit_index;
      code_bits   <= emit_code;
      code_length <= emit_length;
      last_code   <= emit_last;
    end
  end

endmodule
